FILE: rtl/bpfm_pkg.sv
// ----------------------------------------------------------------------------
// Buffer pool frame manager package
// Request and response codes, field widths and the response record.
// ----------------------------------------------------------------------------
`default_nettype none

package bpfm_pkg;

	// Field widths of the request and response channels.
	localparam int unsigned FUNC_W  = 2;
	localparam int unsigned KIND_W  = 3;
	localparam int unsigned FRAME_W = 4;
	localparam int unsigned TABLE_W = 8;
	localparam int unsigned BLOCK_W = 16;

	// Request functions.
	localparam logic [FUNC_W-1:0] FN_ACCESS = 2'd0;
	localparam logic [FUNC_W-1:0] FN_MARK   = 2'd1;
	localparam logic [FUNC_W-1:0] FN_DROP   = 2'd2;
	localparam logic [FUNC_W-1:0] FN_FLUSH  = 2'd3;

	// Response kinds.
	localparam logic [KIND_W-1:0] KIND_HIT   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_FILL  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_WB    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_NF    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DONE  = 3'd4;

	// One response record as it sits in the output register.
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [FRAME_W-1:0] frame;
		logic [TABLE_W-1:0] tag_table;
		logic [BLOCK_W-1:0] tag_block;
		logic               last;
	} rsp_t;

	// Builds a response record from its fields.
	function automatic rsp_t mk_rsp(
		input logic [KIND_W-1:0]  k,
		input logic [FRAME_W-1:0] f,
		input logic [TABLE_W-1:0] tt,
		input logic [BLOCK_W-1:0] tb,
		input logic               l
	);
		rsp_t r;
		r.kind      = k;
		r.frame     = f;
		r.tag_table = tt;
		r.tag_block = tb;
		r.last      = l;
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/buffer_pool_frame_manager_unit.sv
// ----------------------------------------------------------------------------
// Buffer pool frame manager
// Least-frequently-used frame tracking for a block buffer pool: lookup,
// fill, eviction with write-back, dirty marking, table drop and flush.
//
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   func, table_id, block_number
// rsp      out        rsp_valid/rsp_stall   kind, frame, tag_table, tag_block, last
//
// Access, mark and drop read one frame entry per cycle from the tag/count
// memory and load their first response once the whole table is scanned. Flush
// walks the dirty flags, skips clean frames, reports a write-back for each
// dirty frame with its tag read from memory, then loads the done code.
// Reset clears valid, dirty and count-present flags at once; no clearing pass.
// A stalled response holds the reporting states; req_stall is high while it works.
// ----------------------------------------------------------------------------
`default_nettype none

module buffer_pool_frame_manager_unit #(
	parameter int unsigned NUM_FRAMES = 16,
	parameter int unsigned COUNT_BITS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           req_valid,
	output logic                                req_stall,
	input  wire logic [bpfm_pkg::FUNC_W-1:0]    func,
	input  wire logic [bpfm_pkg::TABLE_W-1:0]   table_id,
	input  wire logic [bpfm_pkg::BLOCK_W-1:0]   block_number,
	output logic                                rsp_valid,
	input  wire logic                           rsp_stall,
	output logic [bpfm_pkg::KIND_W-1:0]         kind,
	output logic [bpfm_pkg::FRAME_W-1:0]        frame,
	output logic [bpfm_pkg::TABLE_W-1:0]        tag_table,
	output logic [bpfm_pkg::BLOCK_W-1:0]        tag_block,
	output logic                                last
);

	localparam int unsigned IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int unsigned TAG_W = bpfm_pkg::TABLE_W + bpfm_pkg::BLOCK_W;
	localparam int unsigned ENT_W = TAG_W + COUNT_BITS;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_FRAMES - 1);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_FILL_EV,
		ST_FLUSH,
		ST_FL_RD,
		ST_FL_DONE
	} state_t;

	state_t state_q;

	// Request registers.
	logic [bpfm_pkg::FUNC_W-1:0]  func_q;
	logic [bpfm_pkg::TABLE_W-1:0] t_q;
	logic [bpfm_pkg::BLOCK_W-1:0] b_q;

	// Per-frame flags kept in flip-flops.
	logic [NUM_FRAMES-1:0] valid_q;
	logic [NUM_FRAMES-1:0] dirty_q;
	logic [NUM_FRAMES-1:0] cset_q;

	// Tag and count memory with a registered read.
	logic [ENT_W-1:0] mem [NUM_FRAMES];
	logic [ENT_W-1:0] rd_q;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [COUNT_BITS-1:0] wr_cnt;

	// Scan sequencer and its read pipeline stage.
	logic [IDX_W-1:0] addr_q;
	logic             issue_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [IDX_W-1:0] fidx_q;

	// Scan results.
	logic                         hit_found_q;
	logic [IDX_W-1:0]             hit_idx_q;
	logic [COUNT_BITS-1:0]        hit_cnt_q;
	logic                         empty_found_q;
	logic [IDX_W-1:0]             empty_idx_q;
	logic [COUNT_BITS-1:0]        empty_cnt_q;
	logic [IDX_W-1:0]             min_idx_q;
	logic [COUNT_BITS-1:0]        min_cnt_q;
	logic                         min_dirty_q;
	logic [bpfm_pkg::TABLE_W-1:0] min_table_q;
	logic [bpfm_pkg::BLOCK_W-1:0] min_block_q;

	// Output register.
	logic             rsp_valid_q;
	bpfm_pkg::rsp_t   rsp_q;
	logic             out_free;
	logic             rsp_load;

	// Fields of the entry read last cycle.
	logic [bpfm_pkg::TABLE_W-1:0] rd_table;
	logic [bpfm_pkg::BLOCK_W-1:0] rd_block;
	logic [COUNT_BITS-1:0]        rd_cnt;
	logic [COUNT_BITS-1:0]        s1_cnt;
	logic                         s1_v;
	logic                         s1_hit;

	assign rd_table = rd_q[ENT_W-1 -: bpfm_pkg::TABLE_W];
	assign rd_block = rd_q[COUNT_BITS +: bpfm_pkg::BLOCK_W];
	assign rd_cnt   = rd_q[COUNT_BITS-1:0];

	// A count never written reads as zero.
	assign s1_cnt = cset_q[idx_s1] ? rd_cnt : '0;
	assign s1_v   = valid_q[idx_s1];
	assign s1_hit = s1_v && (rd_table == t_q) && (rd_block == b_q);

	// The output register can take a new response this cycle.
	assign out_free = !rsp_valid_q || !rsp_stall;

	// A response is loaded in this cycle by one of the reporting states.
	assign rsp_load = out_free && (state_q == ST_DECIDE || state_q == ST_FILL_EV ||
		state_q == ST_FL_RD || state_q == ST_FL_DONE);

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign kind      = rsp_q.kind;
	assign frame     = rsp_q.frame;
	assign tag_table = rsp_q.tag_table;
	assign tag_block = rsp_q.tag_block;
	assign last      = rsp_q.last;

	// Memory read address: the scan pointer, or the flush pointer on a dirty frame.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = addr_q;
		if (state_q == ST_SCAN) begin
			rd_en = issue_q;
		end else if (state_q == ST_FLUSH) begin
			rd_en   = dirty_q[fidx_q];
			rd_addr = fidx_q;
		end
	end

	// Memory writes: count update on a hit, new tag on a fill or eviction.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = hit_idx_q;
		wr_cnt  = CNT_ONE;
		if (state_q == ST_DECIDE && func_q == bpfm_pkg::FN_ACCESS && out_free) begin
			if (hit_found_q) begin
				wr_en  = 1'b1;
				wr_cnt = (hit_cnt_q == CNT_MAX) ? hit_cnt_q : hit_cnt_q + CNT_ONE;
			end else if (empty_found_q) begin
				wr_en   = 1'b1;
				wr_addr = empty_idx_q;
				wr_cnt  = empty_cnt_q;
			end else if (!min_dirty_q) begin
				wr_en   = 1'b1;
				wr_addr = min_idx_q;
			end
		end else if (state_q == ST_FILL_EV && out_free) begin
			wr_en   = 1'b1;
			wr_addr = min_idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {t_q, b_q, wr_cnt};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Sequencer, frame flags and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			func_q        <= bpfm_pkg::FN_ACCESS;
			t_q           <= '0;
			b_q           <= '0;
			valid_q       <= '0;
			dirty_q       <= '0;
			cset_q        <= '0;
			addr_q        <= '0;
			issue_q       <= 1'b0;
			rd_vld_s1     <= 1'b0;
			idx_s1        <= '0;
			fidx_q        <= '0;
			hit_found_q   <= 1'b0;
			hit_idx_q     <= '0;
			hit_cnt_q     <= '0;
			empty_found_q <= 1'b0;
			empty_idx_q   <= '0;
			empty_cnt_q   <= '0;
			min_idx_q     <= '0;
			min_cnt_q     <= '0;
			min_dirty_q   <= 1'b0;
			min_table_q   <= '0;
			min_block_q   <= '0;
			rsp_valid_q   <= 1'b0;
			rsp_q         <= '0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			rd_vld_s1 <= (state_q == ST_SCAN) && issue_q;
			idx_s1    <= addr_q;

			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						func_q        <= func;
						t_q           <= table_id;
						b_q           <= block_number;
						addr_q        <= '0;
						fidx_q        <= '0;
						issue_q       <= 1'b1;
						hit_found_q   <= 1'b0;
						empty_found_q <= 1'b0;
						state_q       <= (func == bpfm_pkg::FN_FLUSH) ? ST_FLUSH : ST_SCAN;
					end
				end

				ST_SCAN: begin
					// Issue one read per cycle.
					if (issue_q) begin
						if (addr_q == LAST_IDX) begin
							issue_q <= 1'b0;
						end else begin
							addr_q <= addr_q + 1'b1;
						end
					end
					// Examine the entry read last cycle.
					if (rd_vld_s1) begin
						if (s1_hit && !hit_found_q) begin
							hit_found_q <= 1'b1;
							hit_idx_q   <= idx_s1;
							hit_cnt_q   <= s1_cnt;
						end
						if (!s1_v && !empty_found_q) begin
							empty_found_q <= 1'b1;
							empty_idx_q   <= idx_s1;
							empty_cnt_q   <= s1_cnt;
						end
						if (idx_s1 == '0 || s1_cnt < min_cnt_q) begin
							min_idx_q   <= idx_s1;
							min_cnt_q   <= s1_cnt;
							min_dirty_q <= dirty_q[idx_s1];
							min_table_q <= rd_table;
							min_block_q <= rd_block;
						end
						if (func_q == bpfm_pkg::FN_DROP && s1_v && rd_table == t_q) begin
							valid_q[idx_s1] <= 1'b0;
							dirty_q[idx_s1] <= 1'b0;
						end
						if (idx_s1 == LAST_IDX) begin
							state_q <= ST_DECIDE;
						end
					end
				end

				ST_DECIDE: begin
					if (out_free) begin
						// Only a miss that evicts a dirty frame needs a second response.
						state_q <= (func_q == bpfm_pkg::FN_ACCESS && !hit_found_q &&
							!empty_found_q && min_dirty_q) ? ST_FILL_EV : ST_IDLE;
						unique case (func_q)
							bpfm_pkg::FN_ACCESS: begin
								if (hit_found_q) begin
									cset_q[hit_idx_q] <= 1'b1;
									rsp_q <= bpfm_pkg::mk_rsp(bpfm_pkg::KIND_HIT,
										bpfm_pkg::FRAME_W'(hit_idx_q), t_q, b_q, 1'b1);
								end else if (empty_found_q) begin
									valid_q[empty_idx_q] <= 1'b1;
									dirty_q[empty_idx_q] <= 1'b0;
									cset_q[empty_idx_q]  <= 1'b1;
									rsp_q <= bpfm_pkg::mk_rsp(bpfm_pkg::KIND_FILL,
										bpfm_pkg::FRAME_W'(empty_idx_q), t_q, b_q, 1'b1);
								end else if (min_dirty_q) begin
									// Write-back of the victim first, fill next.
									rsp_q <= bpfm_pkg::mk_rsp(bpfm_pkg::KIND_WB,
										bpfm_pkg::FRAME_W'(min_idx_q), min_table_q,
										min_block_q, 1'b0);
								end else begin
									valid_q[min_idx_q] <= 1'b1;
									dirty_q[min_idx_q] <= 1'b0;
									cset_q[min_idx_q]  <= 1'b1;
									rsp_q <= bpfm_pkg::mk_rsp(bpfm_pkg::KIND_FILL,
										bpfm_pkg::FRAME_W'(min_idx_q), t_q, b_q, 1'b1);
								end
							end
							bpfm_pkg::FN_MARK: begin
								if (hit_found_q) begin
									dirty_q[hit_idx_q] <= 1'b1;
									rsp_q <= bpfm_pkg::mk_rsp(bpfm_pkg::KIND_HIT,
										bpfm_pkg::FRAME_W'(hit_idx_q), t_q, b_q, 1'b1);
								end else begin
									rsp_q <= bpfm_pkg::mk_rsp(bpfm_pkg::KIND_NF,
										'0, t_q, b_q, 1'b1);
								end
							end
							bpfm_pkg::FN_DROP: begin
								rsp_q <= bpfm_pkg::mk_rsp(bpfm_pkg::KIND_DONE,
									'0, t_q, '0, 1'b1);
							end
							bpfm_pkg::FN_FLUSH: begin
								rsp_q <= bpfm_pkg::mk_rsp(bpfm_pkg::KIND_DONE,
									'0, '0, '0, 1'b1);
							end
						endcase
					end
				end

				ST_FILL_EV: begin
					if (out_free) begin
						valid_q[min_idx_q] <= 1'b1;
						dirty_q[min_idx_q] <= 1'b0;
						cset_q[min_idx_q]  <= 1'b1;
						rsp_q <= bpfm_pkg::mk_rsp(bpfm_pkg::KIND_FILL,
							bpfm_pkg::FRAME_W'(min_idx_q), t_q, b_q, 1'b1);
						state_q <= ST_IDLE;
					end
				end

				ST_FLUSH: begin
					// Skip clean frames; a dirty one has its tag read this cycle.
					if (dirty_q[fidx_q]) begin
						state_q <= ST_FL_RD;
					end else if (fidx_q == LAST_IDX) begin
						state_q <= ST_FL_DONE;
					end else begin
						fidx_q <= fidx_q + 1'b1;
					end
				end

				ST_FL_RD: begin
					if (out_free) begin
						rsp_q <= bpfm_pkg::mk_rsp(bpfm_pkg::KIND_WB,
							bpfm_pkg::FRAME_W'(fidx_q), rd_table, rd_block, 1'b0);
						if (fidx_q == LAST_IDX) begin
							state_q <= ST_FL_DONE;
						end else begin
							fidx_q  <= fidx_q + 1'b1;
							state_q <= ST_FLUSH;
						end
					end
				end

				ST_FL_DONE: begin
					if (out_free) begin
						rsp_q <= bpfm_pkg::mk_rsp(bpfm_pkg::KIND_DONE, '0, '0, '0, 1'b1);
						state_q <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	// An accepted request always starts the sequencer.
	a_req_starts: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> state_q != ST_IDLE)
		else $error("sequencer did not leave idle after a request");

	// A response that is not the final one leaves more work pending.
	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_stall && !last |-> state_q != ST_IDLE)
		else $error("non-final response with sequencer idle");

	// A dirty frame is always a valid frame.
	a_dirty_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(dirty_q & ~valid_q) == '0)
		else $error("dirty flag set on an empty frame");
`endif

endmodule

`default_nettype wire
